/* rtl/msc_pkg.sv */
// Shared constants, codes and types of the MSI snooping cache controller.
// No dependencies; used by scoped name by every module of the block but msc_ram.
`default_nettype none

package msc_pkg;

    // sizing
    localparam int NUM_BLOCKS = 16;
    localparam int DATA_WIDTH = 32;
    localparam int BLK_AW     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    // stream widths (113 bits of fields, padded to whole bytes)
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 120;
    localparam int TUSER_W   = 3;
    localparam int FIELDS_W  = 113;

    // command codes (s_tuser)
    localparam logic [2:0] CMD_READ       = 3'd0;
    localparam logic [2:0] CMD_WRITE      = 3'd1;
    localparam logic [2:0] CMD_EVICT      = 3'd2;
    localparam logic [2:0] CMD_SNOOP_GETS = 3'd3;
    localparam logic [2:0] CMD_SNOOP_GETM = 3'd4;
    localparam logic [2:0] CMD_SNOOP_PUTM = 3'd5;
    localparam logic [2:0] CMD_SNOOP_DATA = 3'd6;

    // block states
    localparam logic [2:0] ST_I   = 3'd0;
    localparam logic [2:0] ST_S   = 3'd1;
    localparam logic [2:0] ST_M   = 3'd2;
    localparam logic [2:0] ST_ISD = 3'd3;
    localparam logic [2:0] ST_IMD = 3'd4;
    localparam logic [2:0] ST_SMD = 3'd5;

    // outcome codes (m_tuser)
    localparam logic [2:0] OC_DONE  = 3'd0;
    localparam logic [2:0] OC_WAIT  = 3'd1;
    localparam logic [2:0] OC_RETRY = 3'd2;
    localparam logic [2:0] OC_SNOOP = 3'd3;
    localparam logic [2:0] OC_ERR   = 3'd4;

    // bus message kinds
    localparam logic [2:0] BK_NONE = 3'd0;
    localparam logic [2:0] BK_GETS = 3'd1;
    localparam logic [2:0] BK_GETM = 3'd2;
    localparam logic [2:0] BK_PUTM = 3'd3;
    localparam logic [2:0] BK_DATA = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // item accepted: latch fields, start word read
        logic commit;   // update state and load the output register
    } ctl_t;

endpackage

`default_nettype wire

/* rtl/msc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module msc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                    aclk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/msc_ctrl.sv */
// Sequencer of the cache controller: accept, execute, output handshake.
// Depends on msc_pkg (ctl_t).
`default_nettype none

module msc_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output msc_pkg::ctl_t     ctl
);

    localparam logic SEQ_IDLE = 1'b0;
    localparam logic SEQ_EXEC = 1'b1;

    logic seq_reg, seq_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (seq_reg == SEQ_IDLE);

    always_comb begin
        seq_next     = seq_reg;
        m_valid_next = m_valid_reg;
        ctl.capture  = 1'b0;
        ctl.commit   = 1'b0;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (seq_reg)
            SEQ_IDLE: begin
                if (s_tvalid) begin
                    ctl.capture = 1'b1;
                    seq_next    = SEQ_EXEC;
                end
            end
            SEQ_EXEC: begin
                // hold the item until the output register can take its result
                if (out_free) begin
                    ctl.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    seq_next     = SEQ_IDLE;
                end
            end
            default: begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg     <= SEQ_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            seq_reg     <= seq_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.capture && ctl.commit))
        else $error("capture and commit in the same cycle");

    a_capture_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.capture |=> !s_tready)
        else $error("input still ready after capture");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.commit |=> (m_tvalid && s_tready))
        else $error("commit did not present a result");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_reg == SEQ_EXEC && m_tvalid && !m_tready) |=> (seq_reg == SEQ_EXEC))
        else $error("item left execute while output stalled");

endmodule

`default_nettype wire

/* rtl/msc_dp.sv */
// Datapath of the cache controller: block states, word RAMs, pending
// transaction, protocol decisions and the output register.
// Depends on msc_pkg and msc_ram.
`default_nettype none

module msc_dp (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire msc_pkg::ctl_t                   ctl,
    input  wire logic [msc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [msc_pkg::TUSER_W-1:0]     s_tuser,
    input  wire logic                            cfg_valid,
    input  wire logic [3:0]                      cfg_data,
    output logic      [msc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic      [msc_pkg::TUSER_W-1:0]     m_tuser
);

    localparam int AW = msc_pkg::BLK_AW;
    localparam int DW = msc_pkg::DATA_WIDTH;
    localparam int PAD_W = msc_pkg::M_TDATA_W - msc_pkg::FIELDS_W;

    // latched item
    logic [2:0]    cmd_reg;
    logic [3:0]    blk_reg;
    logic [AW-1:0] idx_reg;
    logic [DW-1:0] wval_reg;
    logic [3:0]    dreg_reg;
    logic [3:0]    sender_reg;
    logic [3:0]    recv_reg;
    logic [DW-1:0] mw0_reg;
    logic [DW-1:0] mw1_reg;
    logic          busy_reg;
    logic          bad_reg;

    // control state
    logic [3:0]    own_id_reg;
    logic          pend_reg, pend_next;
    logic [3:0]    pend_blk_reg, pend_blk_next;
    logic [DW-1:0] pend_val_reg, pend_val_next;
    logic [3:0]    pend_dreg_reg, pend_dreg_next;
    logic [2:0]    state_reg [msc_pkg::NUM_BLOCKS];

    // output register
    logic [msc_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [msc_pkg::TUSER_W-1:0]   m_tuser_reg, m_tuser_next;

    // incoming item
    logic [2:0]    in_cmd;
    logic [3:0]    in_blk;
    logic [AW-1:0] in_idx;
    logic          in_bad;

    // RAM ports
    logic [AW-1:0] raddr;
    logic [DW-1:0] w0_rd, w1_rd;
    logic          w0_we, w1_we;
    logic [DW-1:0] w0_wd, w1_wd;

    // decision
    logic [2:0]    st;
    logic          st_we;
    logic [2:0]    st_wd;
    logic          pend_ok;
    logic          own_sender;
    logic          rwv;
    logic [3:0]    ridx;
    logic [DW-1:0] rdata;
    logic [2:0]    bkind;
    logic [3:0]    bblk;
    logic [DW-1:0] bw0, bw1;
    logic [3:0]    brecv;
    logic          btomem;
    logic [2:0]    outcome;

    assign in_cmd = s_tuser;
    assign in_blk = s_tdata[3:0];
    // a snooped PutM works on the pending block, everything else on the item's block
    assign in_idx = (in_cmd == msc_pkg::CMD_SNOOP_PUTM) ? AW'(pend_blk_reg) : AW'(in_blk);
    assign in_bad = (in_cmd > msc_pkg::CMD_SNOOP_DATA)
                 || (32'(in_blk) >= msc_pkg::NUM_BLOCKS);
    assign raddr  = ctl.capture ? in_idx : idx_reg;

    msc_ram #(.WIDTH(DW), .DEPTH(msc_pkg::NUM_BLOCKS)) u_word0 (
        .aclk  (aclk),
        .we    (w0_we),
        .waddr (idx_reg),
        .wdata (w0_wd),
        .raddr (raddr),
        .rdata (w0_rd)
    );

    msc_ram #(.WIDTH(DW), .DEPTH(msc_pkg::NUM_BLOCKS)) u_word1 (
        .aclk  (aclk),
        .we    (w1_we),
        .waddr (idx_reg),
        .wdata (w1_wd),
        .raddr (raddr),
        .rdata (w1_rd)
    );

    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            cmd_reg    <= in_cmd;
            blk_reg    <= in_blk;
            idx_reg    <= in_idx;
            bad_reg    <= in_bad;
            wval_reg   <= DW'(s_tdata[35:4]);
            dreg_reg   <= s_tdata[39:36];
            sender_reg <= s_tdata[43:40];
            recv_reg   <= s_tdata[47:44];
            mw0_reg    <= DW'(s_tdata[79:48]);
            mw1_reg    <= DW'(s_tdata[111:80]);
            busy_reg   <= s_tdata[112];
        end
    end

    assign st         = state_reg[idx_reg];
    assign pend_ok    = 32'(pend_blk_reg) < msc_pkg::NUM_BLOCKS;
    assign own_sender = (sender_reg == own_id_reg);

    always_comb begin
        outcome        = msc_pkg::OC_ERR;
        rwv            = 1'b0;
        ridx           = '0;
        rdata          = '0;
        bkind          = msc_pkg::BK_NONE;
        bblk           = '0;
        bw0            = '0;
        bw1            = '0;
        brecv          = '0;
        btomem         = 1'b0;
        st_we          = 1'b0;
        st_wd          = msc_pkg::ST_I;
        w0_we          = 1'b0;
        w1_we          = 1'b0;
        w0_wd          = mw0_reg;
        w1_wd          = mw1_reg;
        pend_next      = pend_reg;
        pend_blk_next  = pend_blk_reg;
        pend_val_next  = pend_val_reg;
        pend_dreg_next = pend_dreg_reg;

        if (!bad_reg) begin
            case (cmd_reg)
                msc_pkg::CMD_READ, msc_pkg::CMD_WRITE, msc_pkg::CMD_EVICT: begin
                    if (pend_reg) begin
                        outcome = msc_pkg::OC_RETRY;
                    end else if (st inside {msc_pkg::ST_ISD, msc_pkg::ST_IMD,
                                            msc_pkg::ST_SMD}) begin
                        outcome = msc_pkg::OC_ERR;
                    end else if (cmd_reg == msc_pkg::CMD_READ) begin
                        if (st != msc_pkg::ST_I) begin
                            outcome = msc_pkg::OC_DONE;
                            rwv     = 1'b1;
                            ridx    = dreg_reg;
                            rdata   = w0_rd;
                        end else if (busy_reg) begin
                            outcome = msc_pkg::OC_RETRY;
                        end else begin
                            outcome        = msc_pkg::OC_WAIT;
                            pend_dreg_next = dreg_reg;
                            pend_next      = 1'b1;
                            pend_blk_next  = blk_reg;
                            st_we          = 1'b1;
                            st_wd          = msc_pkg::ST_ISD;
                            bkind          = msc_pkg::BK_GETS;
                            bblk           = blk_reg;
                        end
                    end else if (cmd_reg == msc_pkg::CMD_WRITE) begin
                        if (st == msc_pkg::ST_M) begin
                            outcome = msc_pkg::OC_DONE;
                            w0_we   = 1'b1;
                            w0_wd   = wval_reg;
                        end else if (busy_reg) begin
                            outcome = msc_pkg::OC_RETRY;
                        end else begin
                            outcome       = msc_pkg::OC_WAIT;
                            pend_val_next = wval_reg;
                            pend_next     = 1'b1;
                            pend_blk_next = blk_reg;
                            st_we         = 1'b1;
                            st_wd         = (st == msc_pkg::ST_S) ? msc_pkg::ST_SMD
                                                                  : msc_pkg::ST_IMD;
                            bkind         = msc_pkg::BK_GETM;
                            bblk          = blk_reg;
                        end
                    end else begin
                        // evict
                        if (st == msc_pkg::ST_M) begin
                            if (busy_reg) begin
                                outcome = msc_pkg::OC_RETRY;
                            end else begin
                                outcome       = msc_pkg::OC_WAIT;
                                pend_next     = 1'b1;
                                pend_blk_next = blk_reg;
                                st_we         = 1'b1;
                                st_wd         = msc_pkg::ST_I;
                                bkind         = msc_pkg::BK_PUTM;
                                bblk          = blk_reg;
                            end
                        end else begin
                            outcome = msc_pkg::OC_DONE;
                            st_we   = 1'b1;
                            st_wd   = msc_pkg::ST_I;
                        end
                    end
                end
                msc_pkg::CMD_SNOOP_GETS, msc_pkg::CMD_SNOOP_GETM: begin
                    outcome = msc_pkg::OC_SNOOP;
                    if (own_sender || st == msc_pkg::ST_I) begin
                        outcome = msc_pkg::OC_SNOOP;
                    end else if (st inside {msc_pkg::ST_ISD, msc_pkg::ST_IMD,
                                            msc_pkg::ST_SMD}) begin
                        outcome = msc_pkg::OC_ERR;
                    end else begin
                        if (st == msc_pkg::ST_M) begin
                            bkind  = msc_pkg::BK_DATA;
                            bblk   = blk_reg;
                            bw0    = w0_rd;
                            bw1    = w1_rd;
                            brecv  = sender_reg;
                            btomem = (cmd_reg == msc_pkg::CMD_SNOOP_GETS);
                        end
                        st_we = 1'b1;
                        st_wd = (cmd_reg == msc_pkg::CMD_SNOOP_GETS) ? msc_pkg::ST_S
                                                                     : msc_pkg::ST_I;
                    end
                end
                msc_pkg::CMD_SNOOP_PUTM: begin
                    outcome = msc_pkg::OC_SNOOP;
                    // own PutM seen: the writeback of the evicted block follows
                    if (own_sender && pend_reg && pend_ok && st == msc_pkg::ST_I) begin
                        bkind     = msc_pkg::BK_DATA;
                        bblk      = pend_blk_reg;
                        bw0       = w0_rd;
                        bw1       = w1_rd;
                        brecv     = '0;
                        btomem    = 1'b1;
                        pend_next = 1'b0;
                    end
                end
                msc_pkg::CMD_SNOOP_DATA: begin
                    outcome = msc_pkg::OC_SNOOP;
                    if (recv_reg != own_id_reg) begin
                        outcome = msc_pkg::OC_SNOOP;
                    end else if (!pend_reg || !(st inside {msc_pkg::ST_ISD,
                                 msc_pkg::ST_IMD, msc_pkg::ST_SMD})) begin
                        outcome = msc_pkg::OC_ERR;
                    end else begin
                        pend_next = 1'b0;
                        w0_we     = 1'b1;
                        w1_we     = 1'b1;
                        st_we     = 1'b1;
                        if (st == msc_pkg::ST_ISD) begin
                            st_wd = msc_pkg::ST_S;
                            rwv   = 1'b1;
                            ridx  = pend_dreg_reg;
                            rdata = mw0_reg;
                        end else begin
                            // store miss completes with the pending value merged in
                            st_wd = msc_pkg::ST_M;
                            w0_wd = pend_val_reg;
                        end
                    end
                end
                default: begin
                    outcome = msc_pkg::OC_ERR;
                end
            endcase
        end

        // commit gates every state change
        if (!ctl.commit) begin
            w0_we = 1'b0;
            w1_we = 1'b0;
        end

        m_tuser_next = outcome;
        m_tdata_next = {{PAD_W{1'b0}}, btomem, brecv, 32'(bw1), 32'(bw0), bblk, bkind,
                        32'(rdata), ridx, rwv};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg    <= 4'd1;
            pend_reg      <= 1'b0;
            pend_blk_reg  <= '0;
            pend_val_reg  <= '0;
            pend_dreg_reg <= '0;
            for (int i = 0; i < msc_pkg::NUM_BLOCKS; i++) begin
                state_reg[i] <= msc_pkg::ST_I;
            end
        end else begin
            if (cfg_valid) begin
                own_id_reg <= cfg_data;
            end
            if (ctl.commit) begin
                pend_reg      <= pend_next;
                pend_blk_reg  <= pend_blk_next;
                pend_val_reg  <= pend_val_next;
                pend_dreg_reg <= pend_dreg_next;
                if (st_we) begin
                    state_reg[idx_reg] <= st_wd;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.commit) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

`default_nettype wire

/* rtl/msi_snooping_cache_controller.sv */
// MSI snooping cache controller: top level joining sequencer and datapath.
// Depends on msc_pkg, msc_ctrl, msc_dp (and msc_ram through msc_dp).
//
// Usage
//   s_ channel: one core access or snooped bus message per item. s_tuser
//   carries the command; s_tdata the block, write value, destination
//   register, message sender/receiver, the two Data words and bus_busy.
//   m_ channel: exactly one result item per input item, in order. m_tuser
//   carries the outcome; m_tdata the register write-back and the bus
//   message this cache issues (GetS, GetM, PutM or Data).
//   cfg_ channel: writes own_id (bus identifier); always ready. Write it
//   only while no item is in flight.
// Sequence
//   An accepted item is latched and its block's two words are read from
//   their RAMs (registered read); in execute the block then decides, updates
//   block state and loads the output register once that is free. s_tready
//   is low in execute: a new item is taken only after the last one commits.
//   Results are held in the output register; while it is full and not
//   taken, the next item may be accepted but waits in execute, and
//   s_tready stays low until its result can be loaded.
// Reset
//   aresetn low clears all block states to Invalid, drops the pending
//   transaction, sets own_id to 1 and empties the output register. Data
//   words are not cleared.
`default_nettype none

module msi_snooping_cache_controller (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata, low bit up: block[3:0], write_value[35:4], dest_reg[39:36],
    // msg_sender[43:40], msg_receiver[47:44], msg_word0[79:48],
    // msg_word1[111:80], bus_busy[112], zero pad[119:113]
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [msc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [msc_pkg::TUSER_W-1:0]     s_tuser,   // cmd[2:0]
    // m_tdata, low bit up: reg_write_valid[0], reg_index[4:1],
    // reg_data[36:5], bus_kind[39:37], bus_block[43:40], bus_word0[75:44],
    // bus_word1[107:76], bus_receiver[111:108], bus_to_mem[112], pad[119:113]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [msc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic      [msc_pkg::TUSER_W-1:0]     m_tuser,   // outcome[2:0]
    // own_id write
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [3:0]                      cfg_data
);

    msc_pkg::ctl_t ctl;

    assign cfg_ready = 1'b1;

    msc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    msc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

/* tb/msi_snooping_cache_controller_tb.sv */
// Self-checking testbench for the MSI snooping cache controller.
// Needs msc_pkg and the msi_snooping_cache_controller RTL; reads no files.
// Drives a directed run, then random runs, and checks each result item.
module msi_snooping_cache_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = msc_pkg::DATA_WIDTH;
    localparam int NB = msc_pkg::NUM_BLOCKS;

    // One core access or snooped bus message, as the s_ side carries it.
    typedef struct packed {
        logic [2:0]    cmd;
        logic [3:0]    blk;
        logic [DW-1:0] wval;
        logic [3:0]    dreg;
        logic [3:0]    sender;
        logic [3:0]    receiver;
        logic [DW-1:0] w0;
        logic [DW-1:0] w1;
        logic          busy;
    } access_t;

    // One result item, as the m_ side carries it.
    typedef struct packed {
        logic [2:0]    outcome;
        logic          reg_valid;
        logic [3:0]    reg_index;
        logic [DW-1:0] reg_data;
        logic [2:0]    bus_kind;
        logic [3:0]    bus_block;
        logic [DW-1:0] bus_word0;
        logic [DW-1:0] bus_word1;
        logic [3:0]    bus_receiver;
        logic          bus_to_mem;
    } response_t;

    // Whole coherence state of the cache: line states, data, own transaction.
    typedef struct packed {
        logic [NB-1:0][2:0]      state;
        logic [2*NB-1:0][DW-1:0] words;
        logic                    txn_open;
        logic [3:0]              txn_block;
        logic [DW-1:0]           txn_value;
        logic [3:0]              txn_reg;
        logic [3:0]              bus_id;
    } cache_image_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [msc_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [msc_pkg::TUSER_W-1:0]   s_tuser  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [msc_pkg::M_TDATA_W-1:0] m_tdata;
    logic [msc_pkg::TUSER_W-1:0]   m_tuser;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [3:0]                    cfg_data  = 4'd1;

    // dut_image follows what the block has accepted; gen_image runs ahead
    // with the items already queued, so the generator knows the line states.
    cache_image_t dut_image;
    cache_image_t gen_image;

    access_t   queued_requests[$];
    response_t awaited_responses[$];
    access_t   current_request = '0;

    bit request_taken  = 1'b0;
    bit response_taken = 1'b0;
    int send_gap       = 0;
    int send_calm      = 0;
    int take_gap       = 0;
    int take_calm      = 0;
    int mismatches     = 0;

    msi_snooping_cache_controller DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Advances one cache image by one item and returns the result it owes.
    function automatic response_t coherence_step(inout cache_image_t img,
                                                 input access_t a);
        response_t   r;
        logic [2:0]  st;
        logic [4:0]  lo;
        logic [4:0]  hi;
        r = '0;
        r.outcome = msc_pkg::OC_ERR;
        st = img.state[a.blk];
        lo = {a.blk, 1'b0};
        hi = {a.blk, 1'b1};
        if (a.cmd <= msc_pkg::CMD_EVICT) begin
            // core side; a transient line without own transaction stays an error
            if (img.txn_open) begin
                r.outcome = msc_pkg::OC_RETRY;
            end else if (st < msc_pkg::ST_ISD) begin
                if (a.cmd == msc_pkg::CMD_READ && st != msc_pkg::ST_I) begin
                    r.outcome   = msc_pkg::OC_DONE;
                    r.reg_valid = 1'b1;
                    r.reg_index = a.dreg;
                    r.reg_data  = img.words[lo];
                end else if (a.cmd == msc_pkg::CMD_WRITE && st == msc_pkg::ST_M) begin
                    img.words[lo] = a.wval;
                    r.outcome     = msc_pkg::OC_DONE;
                end else if (a.cmd == msc_pkg::CMD_EVICT && st != msc_pkg::ST_M) begin
                    // shared drops silently, invalid stays invalid
                    img.state[a.blk] = msc_pkg::ST_I;
                    r.outcome        = msc_pkg::OC_DONE;
                end else if (a.busy) begin
                    r.outcome = msc_pkg::OC_RETRY;
                end else begin
                    // own bus transaction starts
                    img.txn_open  = 1'b1;
                    img.txn_block = a.blk;
                    r.outcome     = msc_pkg::OC_WAIT;
                    r.bus_block   = a.blk;
                    case (a.cmd)
                        msc_pkg::CMD_READ: begin
                            img.txn_reg      = a.dreg;
                            img.state[a.blk] = msc_pkg::ST_ISD;
                            r.bus_kind       = msc_pkg::BK_GETS;
                        end
                        msc_pkg::CMD_WRITE: begin
                            img.txn_value    = a.wval;
                            img.state[a.blk] = (st == msc_pkg::ST_S) ? msc_pkg::ST_SMD
                                                                     : msc_pkg::ST_IMD;
                            r.bus_kind       = msc_pkg::BK_GETM;
                        end
                        default: begin
                            img.state[a.blk] = msc_pkg::ST_I;
                            r.bus_kind       = msc_pkg::BK_PUTM;
                        end
                    endcase
                end
            end
        end else if (a.cmd == msc_pkg::CMD_SNOOP_GETS || a.cmd == msc_pkg::CMD_SNOOP_GETM) begin
            r.outcome = msc_pkg::OC_SNOOP;
            if (a.sender != img.bus_id && st != msc_pkg::ST_I) begin
                if (st >= msc_pkg::ST_ISD) begin
                    r.outcome = msc_pkg::OC_ERR;
                end else begin
                    if (st == msc_pkg::ST_M) begin
                        r.bus_kind     = msc_pkg::BK_DATA;
                        r.bus_block    = a.blk;
                        r.bus_word0    = img.words[lo];
                        r.bus_word1    = img.words[hi];
                        r.bus_receiver = a.sender;
                        r.bus_to_mem   = (a.cmd == msc_pkg::CMD_SNOOP_GETS);
                    end
                    img.state[a.blk] = (a.cmd == msc_pkg::CMD_SNOOP_GETS) ? msc_pkg::ST_S
                                                                          : msc_pkg::ST_I;
                end
            end
        end else if (a.cmd == msc_pkg::CMD_SNOOP_PUTM) begin
            r.outcome = msc_pkg::OC_SNOOP;
            // own PutM closes an outstanding evict with the writeback
            if (a.sender == img.bus_id && img.txn_open &&
                img.state[img.txn_block] == msc_pkg::ST_I) begin
                r.bus_kind   = msc_pkg::BK_DATA;
                r.bus_block  = img.txn_block;
                r.bus_word0  = img.words[{img.txn_block, 1'b0}];
                r.bus_word1  = img.words[{img.txn_block, 1'b1}];
                r.bus_to_mem = 1'b1;
                img.txn_open = 1'b0;
            end
        end else if (a.cmd == msc_pkg::CMD_SNOOP_DATA) begin
            r.outcome = msc_pkg::OC_SNOOP;
            if (a.receiver == img.bus_id) begin
                if (st < msc_pkg::ST_ISD || !img.txn_open) begin
                    r.outcome = msc_pkg::OC_ERR;
                end else begin
                    img.words[lo] = a.w0;
                    img.words[hi] = a.w1;
                    img.txn_open  = 1'b0;
                    if (st == msc_pkg::ST_ISD) begin
                        img.state[a.blk] = msc_pkg::ST_S;
                        r.reg_valid      = 1'b1;
                        r.reg_index      = img.txn_reg;
                        r.reg_data       = a.w0;
                    end else begin
                        img.state[a.blk] = msc_pkg::ST_M;
                        img.words[lo]    = img.txn_value;
                    end
                end
            end
        end
        return r;
    endfunction

    // Wait before the next item: mostly short, sometimes long, with calm runs.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(0, 18);
    endfunction

    // Random item shaped by the line states: mostly carries the own
    // transaction to its end, the rest is core traffic and foreign snoops.
    function automatic access_t draw_request();
        access_t    a;
        logic [3:0] id;
        logic [3:0] tb;
        int         pick;
        id         = gen_image.bus_id;
        tb         = gen_image.txn_block;
        a.wval     = $urandom;
        a.dreg     = 4'($urandom_range(0, 15));
        a.sender   = 4'($urandom_range(0, 15));
        a.receiver = 4'($urandom_range(0, 15));
        a.w0       = $urandom;
        a.w1       = $urandom;
        a.busy     = ($urandom_range(0, 3) == 0);
        a.blk      = $urandom_range(0, 1) ? 4'($urandom_range(0, 3))
                                          : 4'($urandom_range(0, 15));
        if (gen_image.txn_open && $urandom_range(0, 9) < 7) begin
            if (gen_image.state[tb] == msc_pkg::ST_I) begin
                a.cmd    = msc_pkg::CMD_SNOOP_PUTM;
                a.sender = id;
            end else if ($urandom_range(0, 2) == 0) begin
                // own request seen on the bus
                a.cmd    = (gen_image.state[tb] == msc_pkg::ST_ISD) ? msc_pkg::CMD_SNOOP_GETS
                                                                    : msc_pkg::CMD_SNOOP_GETM;
                a.sender = id;
                a.blk    = tb;
            end else begin
                a.cmd      = msc_pkg::CMD_SNOOP_DATA;
                a.receiver = id;
                a.blk      = tb;
            end
        end else begin
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2: a.cmd = msc_pkg::CMD_READ;
                3, 4:    a.cmd = msc_pkg::CMD_WRITE;
                5:       a.cmd = msc_pkg::CMD_EVICT;
                6:       a.cmd = msc_pkg::CMD_SNOOP_GETS;
                7:       a.cmd = msc_pkg::CMD_SNOOP_GETM;
                8:       a.cmd = msc_pkg::CMD_SNOOP_PUTM;
                default: a.cmd = msc_pkg::CMD_SNOOP_DATA;
            endcase
            if (a.cmd >= msc_pkg::CMD_SNOOP_GETS && $urandom_range(0, 7) != 0) begin
                while (a.sender == id) a.sender = 4'($urandom_range(0, 15));
            end
            if (a.cmd == msc_pkg::CMD_SNOOP_DATA && $urandom_range(0, 3) != 0) begin
                while (a.receiver == id) a.receiver = 4'($urandom_range(0, 15));
            end
        end
        return a;
    endfunction

    task automatic post(input logic [2:0] cmd, input logic [3:0] blk,
                        input logic [DW-1:0] wval, input logic [3:0] dreg,
                        input logic [3:0] sender, input logic [3:0] receiver,
                        input logic [DW-1:0] w0, input logic [DW-1:0] w1,
                        input logic busy);
        access_t a;
        a = '{cmd, blk, wval, dreg, sender, receiver, w0, w1, busy};
        void'(coherence_step(gen_image, a));
        queued_requests.push_back(a);
    endtask

    task automatic post_random();
        access_t a;
        a = draw_request();
        void'(coherence_step(gen_image, a));
        queued_requests.push_back(a);
    endtask

    // Block idle: every item sent, every result back, pipeline flushed.
    task automatic settle();
        while (queued_requests.size() != 0 || s_tvalid || awaited_responses.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_bus_id(input logic [3:0] id);
        gen_image.bus_id = id;
        @(negedge aclk);
        cfg_data  <= id;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        dut_image.bus_id = id;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [DW-1:0] want,
                               input logic [DW-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Request driver: new item on the falling edge, once the last is taken
    // and its drawn gap has run out.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || request_taken) begin
            request_taken = 1'b0;
            if (send_gap == 0 && queued_requests.size() != 0) begin
                current_request = queued_requests.pop_front();
                s_tdata  <= {7'd0, current_request.busy, current_request.w1,
                             current_request.w0, current_request.receiver,
                             current_request.sender, current_request.dreg,
                             current_request.wval, current_request.blk};
                s_tuser  <= current_request.cmd;
                s_tvalid <= 1'b1;
                send_gap = draw_wait(send_calm);
            end else begin
                s_tvalid <= 1'b0;
                if (send_gap > 0) send_gap--;
            end
        end
    end

    // Accepted request: predict its result right at the handshake.
    always @(posedge aclk) begin
        response_t predicted;
        if (aresetn && s_tvalid && s_tready) begin
            predicted = coherence_step(dut_image, current_request);
            awaited_responses.push_back(predicted);
            request_taken = 1'b1;
        end
    end

    // Result side back-pressure: stall drawn per taken item.
    always @(negedge aclk) begin
        if (response_taken) begin
            response_taken = 1'b0;
            take_gap = draw_wait(take_calm);
        end
        if (take_gap > 0) begin
            m_tready <= 1'b0;
            take_gap--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result monitor: each taken item against the oldest prediction.
    always @(posedge aclk) begin
        response_t seen;
        response_t want;
        if (aresetn && m_tvalid && m_tready) begin
            response_taken    = 1'b1;
            seen.outcome      = m_tuser;
            seen.reg_valid    = m_tdata[0];
            seen.reg_index    = m_tdata[4:1];
            seen.reg_data     = m_tdata[36:5];
            seen.bus_kind     = m_tdata[39:37];
            seen.bus_block    = m_tdata[43:40];
            seen.bus_word0    = m_tdata[75:44];
            seen.bus_word1    = m_tdata[107:76];
            seen.bus_receiver = m_tdata[111:108];
            seen.bus_to_mem   = m_tdata[112];
            if (awaited_responses.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual outcome %0d",
                         $time, m_tuser);
                mismatches++;
            end else begin
                want = awaited_responses.pop_front();
                check_field("outcome", DW'(want.outcome), DW'(seen.outcome));
                check_field("reg_write_valid", DW'(want.reg_valid), DW'(seen.reg_valid));
                check_field("reg_index", DW'(want.reg_index), DW'(seen.reg_index));
                check_field("reg_data", want.reg_data, seen.reg_data);
                check_field("bus_kind", DW'(want.bus_kind), DW'(seen.bus_kind));
                check_field("bus_block", DW'(want.bus_block), DW'(seen.bus_block));
                check_field("bus_word0", want.bus_word0, seen.bus_word0);
                check_field("bus_word1", want.bus_word1, seen.bus_word1);
                check_field("bus_receiver", DW'(want.bus_receiver),
                            DW'(seen.bus_receiver));
                check_field("bus_to_mem", DW'(want.bus_to_mem), DW'(seen.bus_to_mem));
                check_field("m_tdata pad", '0, DW'(m_tdata[119:113]));
            end
        end
    end

    initial begin
        logic [3:0] ids [4];
        dut_image        = '0;
        dut_image.bus_id = 4'd1;
        gen_image        = dut_image;
        ids = '{4'd15, 4'($urandom_range(2, 14)), 4'd1, 4'($urandom_range(1, 15))};

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed run with the reset id (1).
        // args: cmd, block, write value, dest reg, sender, receiver, word0, word1, busy
        post(msc_pkg::CMD_READ,       4'd0,  '0, 4'd3,  4'd0,  4'd0, '0, '0, 1'b0); // GetS
        post(msc_pkg::CMD_WRITE,      4'd0,  '1, 4'd0,  4'd0,  4'd0, '0, '0, 1'b0); // retry
        post(msc_pkg::CMD_SNOOP_GETS, 4'd0,  '0, 4'd0,  4'd1,  4'd0, '0, '0, 1'b0); // own echo
        post(msc_pkg::CMD_SNOOP_GETM, 4'd0,  '0, 4'd0,  4'd2,  4'd0, '0, '0, 1'b0); // error
        post(msc_pkg::CMD_SNOOP_PUTM, 4'd0,  '0, 4'd0,  4'd1,  4'd0, '0, '0, 1'b0); // no evict
        post(msc_pkg::CMD_SNOOP_DATA, 4'd0,  '0, 4'd0,  4'd0,  4'd1, '1, '0, 1'b0); // fill S
        post(msc_pkg::CMD_READ,       4'd0,  '0, 4'd15, 4'd0,  4'd0, '0, '0, 1'b1); // hit busy
        post(msc_pkg::CMD_SNOOP_GETS, 4'd0,  '0, 4'd0,  4'd5,  4'd0, '0, '0, 1'b0); // S stays
        post(msc_pkg::CMD_WRITE,      4'd0,  '1, 4'd0,  4'd0,  4'd0, '0, '0, 1'b0); // upgrade
        post(msc_pkg::CMD_SNOOP_DATA, 4'd0,  '0, 4'd0,  4'd0,  4'd1, '0, '1, 1'b0); // to M
        post(msc_pkg::CMD_WRITE,      4'd0,  '0, 4'd0,  4'd0,  4'd0, '0, '0, 1'b1); // hit busy
        post(msc_pkg::CMD_SNOOP_DATA, 4'd0,  '0, 4'd0,  4'd0,  4'd1, '1, '1, 1'b0); // error
        post(msc_pkg::CMD_SNOOP_DATA, 4'd5,  '0, 4'd0,  4'd0,  4'd3, '1, '1, 1'b0); // not ours
        post(msc_pkg::CMD_SNOOP_GETS, 4'd0,  '0, 4'd0,  4'd0,  4'd0, '0, '0, 1'b0); // M supply
        post(msc_pkg::CMD_EVICT,      4'd0,  '0, 4'd0,  4'd0,  4'd0, '0, '0, 1'b0); // S drops
        post(msc_pkg::CMD_EVICT,      4'd0,  '0, 4'd0,  4'd0,  4'd0, '0, '0, 1'b0); // I no-op
        post(msc_pkg::CMD_WRITE,      4'd15, '1, 4'd0,  4'd0,  4'd0, '0, '0, 1'b1); // miss busy
        post(msc_pkg::CMD_WRITE,      4'd15, 32'h8000_0001, 4'd0, 4'd0, 4'd0, '0, '0, 1'b0);
        post(msc_pkg::CMD_SNOOP_DATA, 4'd15, '0, 4'd0,  4'd0,  4'd1, '1, '1, 1'b0); // to M
        post(msc_pkg::CMD_SNOOP_GETM, 4'd15, '0, 4'd0,  4'd15, 4'd0, '0, '0, 1'b0); // to I
        post(msc_pkg::CMD_WRITE,      4'd15, 32'h7FFF_FFFE, 4'd0, 4'd0, 4'd0, '0, '0, 1'b0);
        post(msc_pkg::CMD_SNOOP_DATA, 4'd15, '0, 4'd0,  4'd0,  4'd1, 32'h1234_5678, '0, 1'b0);
        post(msc_pkg::CMD_EVICT,      4'd15, '0, 4'd0,  4'd0,  4'd0, '0, '0, 1'b1); // M busy
        post(msc_pkg::CMD_EVICT,      4'd15, '0, 4'd0,  4'd0,  4'd0, '0, '0, 1'b0); // PutM
        post(msc_pkg::CMD_SNOOP_PUTM, 4'd15, '0, 4'd0,  4'd4,  4'd0, '0, '0, 1'b0); // foreign
        post(msc_pkg::CMD_SNOOP_PUTM, 4'd3,  '0, 4'd0,  4'd1,  4'd0, '0, '0, 1'b0); // wback
        settle();

        // Random runs, each under its own bus id, the extremes among them.
        foreach (ids[p]) begin
            program_bus_id(ids[p]);
            repeat (250) post_random();
            settle();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog, well past the slowest legal run.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
